/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold while out of reset.
`define CHD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

// The antecedent implies the consequent in the cycle after.
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/chd_pkg.sv */
// Shared constants and types of the canonical Huffman decoder.
// No dependencies.
package chd_pkg;

	localparam int MAX_CODE_LEN = 16;
	localparam int MAX_SYMBOLS  = 256;
	localparam int BYTE_BITS    = 8;
	localparam logic [BYTE_BITS-1:0] TABLE_END = 8'hff;

	// Code length counter holds 0 .. MAX_CODE_LEN+1.
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 2);
	// Canonical codes are kept one bit wider than the longest length.
	localparam int CODE_W  = MAX_CODE_LEN + 1;
	localparam int ACC_W   = MAX_CODE_LEN;
	localparam int LIDX_W  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
	// Symbol count / index holds 0 .. MAX_SYMBOLS.
	localparam int SIDX_W  = $clog2(MAX_SYMBOLS + 1);
	localparam int SADDR_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int BCNT_W  = $clog2(BYTE_BITS);

	// Stream parsing phase.
	typedef enum logic [1:0] {
		PH_COUNT,
		PH_SYMS,
		PH_DATA
	} phase_t;

	// Bit-serial control sequencer.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_FLUSH
	} state_t;

endpackage

/* hw/rtl/chd_in_if.sv */
// Input channel of the decoder: one table or bitstream byte per item.
// Depends on chd_pkg.
interface chd_in_if;
	logic                          valid;
	logic                          ready;
	logic [chd_pkg::BYTE_BITS-1:0] in_byte;
	logic                          new_stream;

	modport source (output valid, output in_byte, output new_stream, input ready);
	modport sink (input valid, input in_byte, input new_stream, output ready);
endinterface

/* hw/rtl/chd_out_if.sv */
// Output channel of the decoder: one decoded symbol or error per item.
// Depends on chd_pkg.
interface chd_out_if;
	logic                          valid;
	logic                          ready;
	logic [chd_pkg::BYTE_BITS-1:0] symbol;
	logic                          error;
	logic                          last;

	modport source (output valid, output symbol, output error, output last, input ready);
	modport sink (input valid, input symbol, input error, input last, output ready);
endinterface

/* hw/rtl/chd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/canonical_huffman_decoder.sv */
// Canonical Huffman decoder: builds the code table from count/symbol bytes, then
// decodes the bitstream one bit per cycle unless the output stalls. Depends on chd_pkg,
// chd_in_if, chd_out_if, chd_ram. A table byte is taken on acceptance; a data byte
// is accepted, shifted through its bit steps, then flushed, waiting while the output
// stalls. A result is held until the next hit or the flush loads the output register.
// arst_n clears control and code tables; the symbol store is undefined until loaded.
module canonical_huffman_decoder (
	input logic      clk,
	input logic      arst_n,
	chd_in_if.sink   din,
	chd_out_if.source dout
);
	import chd_pkg::*;

	`include "assert_macros.svh"

	// Table-building state.
	phase_t              phase_q;
	logic [BYTE_BITS-1:0] left_q;
	logic [LEN_W-1:0]    cur_len_q;
	logic [CODE_W-1:0]   next_code_q;
	logic [SIDX_W-1:0]   loaded_q;
	logic [CODE_W-1:0]   first_code_q [MAX_CODE_LEN];
	logic [SIDX_W-1:0]   first_idx_q [MAX_CODE_LEN];
	logic [SIDX_W-1:0]   sym_cnt_q [MAX_CODE_LEN];

	// Bit-serial decode state.
	state_t              state_q, state_d;
	logic [BYTE_BITS-1:0] shift_q;
	logic [BCNT_W-1:0]   bit_cnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [LEN_W-1:0]    bits_q;

	// Pending result, held until the next result or the end of the byte sets last.
	logic                pend_valid_q;
	logic                pend_err_q;
	logic                pend_zero_q;

	// Output register.
	logic                out_valid_q;
	logic [BYTE_BITS-1:0] out_sym_q;
	logic                out_err_q;
	logic                out_last_q;

	// Control decode.
	logic in_acc, take_cnt, take_sym, take_dat, out_can_load, step_en;
	logic out_load, out_last, rd_en, sym_in_range;

	// Count-byte evaluation.
	logic [LEN_W-1:0]    eff_len;
	logic [CODE_W-1:0]   eff_code;
	logic [SIDX_W-1:0]   eff_loaded;
	logic [LEN_W-1:0]    len_inc;
	logic                len_ok;
	logic [CODE_W-1:0]   code_shift;
	logic [LIDX_W-1:0]   cnt_lidx;
	logic [LIDX_W-1:0]   sym_lidx;

	// Bit-step match evaluation.
	logic                cur_bit;
	logic [ACC_W-1:0]    acc_next;
	logic [LEN_W-1:0]    len_next;
	logic [LIDX_W-1:0]   look_lidx;
	logic [CODE_W-1:0]   sel_code;
	logic [SIDX_W-1:0]   sel_cnt;
	logic [SIDX_W-1:0]   sel_first;
	logic [CODE_W:0]     diff;
	logic                match, err_hit, hit;
	logic [SIDX_W:0]     sym_idx;
	logic [BYTE_BITS-1:0] ram_rdata;
	logic [BYTE_BITS-1:0] pend_sym;

	// Handshake and step control.
	always_comb begin
		din.ready    = (state_q == ST_IDLE);
		in_acc       = din.valid && din.ready;
		take_cnt     = in_acc && (din.new_stream || phase_q == PH_COUNT);
		take_sym     = in_acc && !din.new_stream && phase_q == PH_SYMS;
		take_dat     = in_acc && !din.new_stream && phase_q == PH_DATA;
		out_can_load = !out_valid_q || dout.ready;
		step_en      = (state_q == ST_BITS) && !(hit && pend_valid_q && !out_can_load);
		out_load     = (step_en && hit && pend_valid_q) ||
		               (state_q == ST_FLUSH && pend_valid_q && out_can_load);
		out_last     = (state_q == ST_FLUSH);
		rd_en        = step_en && match;
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_dat) state_d = ST_BITS;
			end
			ST_BITS: begin
				if (step_en && bit_cnt_q == '0) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Count byte: a new stream starts from cleared table state.
	always_comb begin
		eff_len    = din.new_stream ? '0 : cur_len_q;
		eff_code   = din.new_stream ? '0 : next_code_q;
		eff_loaded = din.new_stream ? '0 : loaded_q;
		len_inc    = (eff_len <= LEN_W'(MAX_CODE_LEN)) ? LEN_W'(eff_len + 1'b1) : eff_len;
		len_ok     = (len_inc <= LEN_W'(MAX_CODE_LEN));
		code_shift = (len_inc > LEN_W'(1)) ? {eff_code[CODE_W-2:0], 1'b0} : eff_code;
		cnt_lidx   = LIDX_W'(len_inc - 1'b1);
		sym_lidx   = LIDX_W'(cur_len_q - 1'b1);
		sym_in_range = (cur_len_q != '0) && (cur_len_q <= LEN_W'(MAX_CODE_LEN)) &&
		               (loaded_q < SIDX_W'(MAX_SYMBOLS));
	end

	// One bit step: shift in the next bit and check the codes of that length.
	always_comb begin
		cur_bit   = shift_q[BYTE_BITS-1];
		acc_next  = {acc_q[ACC_W-2:0], cur_bit};
		len_next  = LEN_W'(bits_q + 1'b1);
		look_lidx = LIDX_W'(len_next - 1'b1);
		sel_code  = first_code_q[look_lidx];
		sel_cnt   = sym_cnt_q[look_lidx];
		sel_first = first_idx_q[look_lidx];
		diff      = {2'b00, acc_next} - {1'b0, sel_code};
		match     = !diff[CODE_W] && (diff[CODE_W-1:0] < CODE_W'(sel_cnt));
		err_hit   = !match && (len_next >= LEN_W'(MAX_CODE_LEN));
		hit       = match || err_hit;
		sym_idx   = {1'b0, sel_first} + (SIDX_W + 1)'(diff[SIDX_W-1:0]);
		pend_sym  = pend_zero_q ? '0 : ram_rdata;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table building from count and symbol bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			left_q      <= '0;
			cur_len_q   <= '0;
			next_code_q <= '0;
			loaded_q    <= '0;
			for (int i = 0; i < MAX_CODE_LEN; i++) begin
				first_code_q[i] <= '0;
				first_idx_q[i]  <= '0;
				sym_cnt_q[i]    <= '0;
			end
		end else if (take_cnt) begin
			if (din.new_stream) begin
				for (int i = 0; i < MAX_CODE_LEN; i++) begin
					sym_cnt_q[i] <= '0;
				end
			end
			if (din.in_byte == TABLE_END) begin
				phase_q     <= PH_DATA;
				cur_len_q   <= eff_len;
				next_code_q <= eff_code;
				loaded_q    <= eff_loaded;
			end else begin
				cur_len_q <= len_inc;
				loaded_q  <= eff_loaded;
				left_q    <= din.in_byte;
				phase_q   <= (din.in_byte != '0) ? PH_SYMS : PH_COUNT;
				if (len_ok) begin
					next_code_q            <= code_shift;
					first_code_q[cnt_lidx] <= code_shift;
					first_idx_q[cnt_lidx]  <= eff_loaded;
					// A new stream has already cleared every count.
					if (!din.new_stream) begin
						sym_cnt_q[cnt_lidx] <= '0;
					end
				end else begin
					next_code_q <= eff_code;
				end
			end
		end else if (take_sym) begin
			if (sym_in_range) begin
				loaded_q            <= SIDX_W'(loaded_q + 1'b1);
				sym_cnt_q[sym_lidx] <= SIDX_W'(sym_cnt_q[sym_lidx] + 1'b1);
				next_code_q         <= CODE_W'(next_code_q + 1'b1);
			end
			left_q <= BYTE_BITS'(left_q - 1'b1);
			if (left_q <= BYTE_BITS'(1)) phase_q <= PH_COUNT;
		end
	end

	// Bit shifter, code accumulator and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q    <= '0;
			acc_q        <= '0;
			bits_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_err_q   <= 1'b0;
			pend_zero_q  <= 1'b0;
		end else if (take_cnt && din.new_stream) begin
			acc_q  <= '0;
			bits_q <= '0;
		end else if (take_dat) begin
			bit_cnt_q <= BCNT_W'(BYTE_BITS - 1);
		end else if (step_en) begin
			bit_cnt_q <= BCNT_W'(bit_cnt_q - 1'b1);
			if (hit) begin
				acc_q        <= '0;
				bits_q       <= '0;
				pend_valid_q <= 1'b1;
				pend_err_q   <= err_hit;
				pend_zero_q  <= err_hit || (sym_idx >= (SIDX_W + 1)'(MAX_SYMBOLS));
			end else begin
				acc_q  <= acc_next;
				bits_q <= len_next;
			end
		end else if (state_q == ST_FLUSH && out_can_load) begin
			pend_valid_q <= 1'b0;
		end
	end

	// The byte itself needs no reset.
	always_ff @(posedge clk) begin
		if (take_dat) begin
			shift_q <= din.in_byte;
		end else if (step_en) begin
			shift_q <= {shift_q[BYTE_BITS-2:0], 1'b0};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sym_q  <= pend_sym;
			out_err_q  <= pend_err_q;
			out_last_q <= out_last;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.symbol = out_sym_q;
	assign dout.error  = out_err_q;
	assign dout.last   = out_last_q;

	// Symbol store, filled in table order and read by the decoded index.
	chd_ram #(
		.WIDTH (BYTE_BITS),
		.DEPTH (MAX_SYMBOLS)
	) u_store (
		.clk     (clk),
		.wr_en   (take_sym && sym_in_range),
		.wr_addr (loaded_q[SADDR_W-1:0]),
		.wr_data (din.in_byte),
		.rd_en   (rd_en),
		.rd_addr (sym_idx[SADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	// Consistency checks.
	`CHD_ASSERT_NEVER(a_no_pend_idle, clk, arst_n,
		state_q == ST_IDLE && pend_valid_q, "pending result left behind after a byte")
	`CHD_ASSERT_NEVER(a_bits_bound, clk, arst_n,
		bits_q >= LEN_W'(MAX_CODE_LEN), "accumulator reached full length without a result")
	`CHD_ASSERT_NEXT(a_flush_last, clk, arst_n,
		state_q == ST_FLUSH && pend_valid_q && out_can_load,
		out_valid_q && out_last_q, "final result of a byte not marked last")
	`CHD_ASSERT_NEVER(a_read_in_bits, clk, arst_n,
		rd_en && state_q != ST_BITS, "symbol store read outside bit decoding")

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the canonical Huffman decoder: directed rows, then random streams.
// Depends on chd_pkg, chd_in_if, chd_out_if and canonical_huffman_decoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import chd_pkg::*;

	localparam int LIMIT        = 200000;
	localparam int STALL_CYCLES = 300;
	localparam int N_DIRECTED   = 24;

	// One decoded symbol or error, as the output channel carries it.
	typedef struct packed {
		logic [BYTE_BITS-1:0] symbol;
		logic                 error;
		logic                 last;
	} result_t;

	// How a directed row is checked.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_SINGLE
	} row_kind_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] in_byte;
		logic                 new_stream;
		row_kind_t            kind;
		logic [BYTE_BITS-1:0] exp_symbol;
		logic                 exp_error;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic [BYTE_BITS-1:0] in_byte_q = '0;
	logic                 in_ns = 1'b0;
	logic                 out_ready = 1'b0;

	chd_in_if  din_if ();
	chd_out_if dout_if ();

	assign din_if.valid      = in_valid;
	assign din_if.in_byte    = in_byte_q;
	assign din_if.new_stream = in_ns;
	assign dout_if.ready     = out_ready;

	canonical_huffman_decoder uut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	// Clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decoder state as the predictor sees it.
	phase_t               dec_phase;
	logic [BYTE_BITS-1:0] syms_left;
	logic [LEN_W-1:0]     cur_len;
	logic [CODE_W-1:0]    nxt_code;
	logic [SIDX_W-1:0]    syms_loaded;
	logic [BYTE_BITS-1:0] sym_store [MAX_SYMBOLS];
	logic [CODE_W-1:0]    first_code [MAX_CODE_LEN+1];
	logic [SIDX_W-1:0]    first_index [MAX_CODE_LEN+1];
	logic [SIDX_W-1:0]    sym_count [MAX_CODE_LEN+1];
	logic [ACC_W-1:0]     code_acc;
	logic [LEN_W-1:0]     bits_acc;

	result_t byte_results [$];
	result_t decoded_q [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int in_count = 0;
	int mismatches = 0;
	int n_symbols = 0;
	int n_errors = 0;
	int cycles = 0;
	int hold_left = 0;
	bit stall_go = 1'b0;
	bit stall_done = 1'b0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Empty table straight after reset: an error after sixteen bits.
		'{8'hff, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'hff, 1'b0, ROW_SINGLE, 8'h00, 1'b1},
		// Lengths 1, 2, 3 with one, one and two symbols.
		'{8'h01, 1'b1, ROW_SILENT, 8'h00, 1'b0},
		'{8'ha5, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h01, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h3c, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h02, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'hff, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'hff, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_PREDICT, 8'h00, 1'b0},
		'{8'hb7, 1'b0, ROW_PREDICT, 8'h00, 1'b0},
		// Leaves two padding bits behind for the next stream to drop.
		'{8'hff, 1'b0, ROW_PREDICT, 8'h00, 1'b0},
		// Zero counts for lengths 1 and 2.
		'{8'h00, 1'b1, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h01, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h7e, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'hff, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_PREDICT, 8'h00, 1'b0},
		// Empty table opened by a new stream.
		'{8'hff, 1'b1, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_SILENT, 8'h00, 1'b0},
		'{8'h00, 1'b0, ROW_SINGLE, 8'h00, 1'b1},
		'{8'h80, 1'b0, ROW_PREDICT, 8'h00, 1'b0}
	};

	// Drop the code table and the accumulator.
	task automatic clear_stream();
		dec_phase   = PH_COUNT;
		syms_left   = '0;
		cur_len     = '0;
		nxt_code    = '0;
		syms_loaded = '0;
		code_acc    = '0;
		bits_acc    = '0;
		for (int i = 0; i <= MAX_CODE_LEN; i++) begin
			first_code[i]  = '0;
			first_index[i] = '0;
			sym_count[i]   = '0;
		end
	endtask

	// A count byte opens the next code length, or ends the table.
	task automatic take_count(input logic [BYTE_BITS-1:0] b);
		if (b == TABLE_END) begin
			dec_phase = PH_DATA;
			return;
		end
		if (cur_len <= MAX_CODE_LEN)
			cur_len++;
		if (cur_len <= MAX_CODE_LEN) begin
			if (cur_len > 1)
				nxt_code = nxt_code << 1;
			first_code[cur_len]  = nxt_code;
			first_index[cur_len] = syms_loaded;
			sym_count[cur_len]   = '0;
		end
		syms_left = b;
		dec_phase = (b != 0) ? PH_SYMS : PH_COUNT;
	endtask

	// Advance the predicted state by one byte; its results land in byte_results.
	task automatic decode_byte(input logic [BYTE_BITS-1:0] b, input logic ns);
		result_t           r;
		logic [CODE_W-1:0] diff;
		logic [LEN_W-1:0]  len;
		int                idx;
		byte_results.delete();
		if (ns) begin
			clear_stream();
			take_count(b);
			return;
		end
		case (dec_phase)
			PH_COUNT: take_count(b);
			PH_SYMS: begin
				// Symbols past the longest length or a full store are discarded.
				if (cur_len >= 1 && cur_len <= MAX_CODE_LEN && syms_loaded < MAX_SYMBOLS) begin
					sym_store[syms_loaded] = b;
					syms_loaded++;
					sym_count[cur_len]++;
					nxt_code = nxt_code + 1'b1;
				end
				if (syms_left > 0)
					syms_left--;
				if (syms_left == 0)
					dec_phase = PH_COUNT;
			end
			default: begin
				// Bit-serial decode, MSB first; a match needs the exact length.
				for (int i = BYTE_BITS - 1; i >= 0; i--) begin
					code_acc = {code_acc[ACC_W-2:0], b[i]};
					if (bits_acc < MAX_CODE_LEN)
						bits_acc++;
					len  = bits_acc;
					diff = {1'b0, code_acc} - first_code[len];
					if (sym_count[len] != 0 && {1'b0, code_acc} >= first_code[len] &&
						diff < sym_count[len]) begin
						idx      = int'(first_index[len]) + int'(diff);
						r.symbol = (idx < MAX_SYMBOLS) ? sym_store[idx] : '0;
						r.error  = 1'b0;
						r.last   = 1'b0;
						byte_results = {byte_results, r};
						code_acc = '0;
						bits_acc = '0;
					end else if (len >= MAX_CODE_LEN) begin
						r = '{symbol: '0, error: 1'b1, last: 1'b0};
						byte_results = {byte_results, r};
						code_acc = '0;
						bits_acc = '0;
					end
				end
				if (byte_results.size() > 0) begin
					r = byte_results.pop_back();
					r.last = 1'b1;
					byte_results = {byte_results, r};
				end
			end
		endcase
	endtask

	// Offer one item and wait until the block takes it.
	task automatic offer_byte(input logic [BYTE_BITS-1:0] b, input logic ns);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte_q <= b;
		in_ns     <= ns;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		in_count++;
	endtask

	// Offer one item and queue what it should decode to.
	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic ns);
		offer_byte(b, ns);
		decode_byte(b, ns);
		decoded_q = {decoded_q, byte_results};
	endtask

	// A well-formed table with random symbols, then random data bytes.
	task automatic send_code_stream(input int data_len);
		int max_len;
		int avail;
		int cnt;
		bit complete;
		bit first;
		max_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, MAX_CODE_LEN) :
			$urandom_range(1, 8);
		complete = ($urandom_range(0, 4) != 0);
		avail    = 2;
		first    = 1'b1;
		for (int len = 1; len <= max_len && avail > 0; len++) begin
			// Keep at most two free codes per length so tables stay short.
			if (len == max_len && complete)
				cnt = avail;
			else
				cnt = $urandom_range((avail >= 2) ? avail - 2 : 0, avail);
			send_byte(BYTE_BITS'(cnt), first);
			first = 1'b0;
			repeat (cnt)
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
			avail = 2 * (avail - cnt);
		end
		send_byte(TABLE_END, first);
		repeat (data_len)
			send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
	endtask

	// Pick one kind of stream: mostly well formed, some odd tables and noise.
	task automatic send_random_stream();
		int pick;
		int n;
		int cnt;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_code_stream($urandom_range(3, 10));
		end else if (pick < 78) begin
			// Oversubscribed: more codes than the short lengths can hold.
			send_byte(BYTE_BITS'($urandom_range(3, 6)), 1'b1);
			repeat (in_byte_q)
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
			cnt = $urandom_range(0, 3);
			send_byte(BYTE_BITS'(cnt), 1'b0);
			repeat (cnt)
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
			send_byte(TABLE_END, 1'b0);
			repeat ($urandom_range(3, 8))
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 84) begin
			// Count bytes run past the longest code length.
			n = $urandom_range(MAX_CODE_LEN + 1, MAX_CODE_LEN + 4);
			for (int len = 1; len <= n; len++) begin
				if (len > MAX_CODE_LEN)
					cnt = $urandom_range(1, 2);
				else
					cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				send_byte(BYTE_BITS'(cnt), len == 1);
				repeat (cnt)
					send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
			end
			send_byte(TABLE_END, 1'b0);
			repeat ($urandom_range(3, 8))
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 90) begin
			// Empty table: only errors come out.
			send_byte(TABLE_END, 1'b1);
			repeat ($urandom_range(2, 5))
				send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
		end else begin
			// Noise, including streams cut off in the middle of the table.
			repeat ($urandom_range(4, 10))
				send_byte(BYTE_BITS'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		end
	endtask

	// Output side: compare each accepted result, and stall at random.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (dout_if.valid && out_ready) begin
				if (dout_if.error)
					n_errors++;
				else
					n_symbols++;
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result symbol %h error %b last %b", $time,
						dout_if.symbol, dout_if.error, dout_if.last);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (dout_if.symbol !== want.symbol) begin
						$display("%0t: symbol expected %h actual %h", $time, want.symbol,
							dout_if.symbol);
						mismatches++;
					end
					if (dout_if.error !== want.error) begin
						$display("%0t: error expected %b actual %b", $time, want.error,
							dout_if.error);
						mismatches++;
					end
					if (dout_if.last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last,
							dout_if.last);
						mismatches++;
					end
				end
			end
			// One long hold-off on request, otherwise random stalls.
			if (stall_go && !stall_done) begin
				hold_left  = STALL_CYCLES;
				stall_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		int start;
		result_t exp_r;
		dec_phase = PH_COUNT;
		clear_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, sender rarely idle and receiver mostly stalled.
		src_idle_pct = 8;
		snk_idle_pct = 82;
		foreach (directed_rows[i]) begin
			offer_byte(directed_rows[i].in_byte, directed_rows[i].new_stream);
			decode_byte(directed_rows[i].in_byte, directed_rows[i].new_stream);
			case (directed_rows[i].kind)
				ROW_PREDICT: begin
					decoded_q = {decoded_q, byte_results};
				end
				ROW_SINGLE: begin
					exp_r.symbol = directed_rows[i].exp_symbol;
					exp_r.error  = directed_rows[i].exp_error;
					exp_r.last   = 1'b1;
					decoded_q    = {decoded_q, exp_r};
				end
				default: begin
				end
			endcase
		end

		// Random streams in three idling regimes.
		start = in_count;
		while (in_count - start < 60)
			send_random_stream();
		src_idle_pct = 82;
		snk_idle_pct = 8;
		while (in_count - start < 120)
			send_random_stream();
		src_idle_pct = 0;
		snk_idle_pct = 0;

		// Long receiver hold-off while data items keep coming.
		stall_go = 1'b1;
		send_code_stream(24);
		while (in_count < 200)
			send_random_stream();

		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d items: directed rows, canonical, oversubscribed, over-length,",
			in_count);
		$display("empty and noisy streams; %0d symbols, %0d errors, %0d mismatches",
			n_symbols, n_errors, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* canonical_huffman_decoder.f */
+incdir+hw/rtl
hw/rtl/chd_pkg.sv
hw/rtl/chd_in_if.sv
hw/rtl/chd_out_if.sv
hw/rtl/chd_ram.sv
hw/rtl/canonical_huffman_decoder.sv
verif/testbench.sv
